// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the touch conditioner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tpsd_pkg
// Types, constants and helper functions shared by the touch conditioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpsd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam int RES_W   = 11;
  localparam int SCALE_W = 16;
  localparam int EDGE_W  = 12;
  localparam int PT_W    = 10;
  localparam int FRAC_W  = 12;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [RES_W-1:0] RES_MAX = 11'd1024;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_HOR_RES      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VER_RES      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_X_SCALE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_SCALE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM_EDGE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_MARGIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MIN_RISE     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MAX_SIDEWAYS = 3'd7;

  // Reset values
  localparam logic [RES_W-1:0]   RST_HOR_RES      = 11'd240;
  localparam logic [RES_W-1:0]   RST_VER_RES      = 11'd240;
  localparam logic [SCALE_W-1:0] RST_X_SCALE      = 16'd4096;
  localparam logic [SCALE_W-1:0] RST_Y_SCALE      = 16'd4096;
  localparam logic [EDGE_W-1:0]  RST_BOTTOM_EDGE  = 12'd240;
  localparam logic [EDGE_W-1:0]  RST_EDGE_MARGIN  = 12'd60;
  localparam logic [EDGE_W-1:0]  RST_MIN_RISE     = 12'd60;
  localparam logic [EDGE_W-1:0]  RST_MAX_SIDEWAYS = 12'd80;

  typedef struct packed {
    logic [RES_W-1:0]   hor_res;
    logic [RES_W-1:0]   ver_res;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [EDGE_W-1:0]  bottom_edge;
    logic [EDGE_W-1:0]  edge_margin;
    logic [EDGE_W-1:0]  min_rise;
    logic [EDGE_W-1:0]  max_sideways;
  } cfg_t;

  // Classification of one poll, handed from the front to the back.
  typedef struct packed {
    logic pressed;
    logic swipe;
  } flags_t;

  typedef struct packed {
    logic            pressed;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
    logic            swipe_home;
  } res_t;

  // A resolution of zero acts as one, anything above 1024 as 1024.
  function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
    if (r == '0) begin
      return RES_W'(1);
    end else if (r > RES_MAX) begin
      return RES_MAX;
    end
    return r;
  endfunction

  function automatic logic [PT_W-1:0] clamp_pt(input logic [PT_W-1:0] v,
                                               input logic [RES_W-1:0] res);
    logic [RES_W-1:0] resm1;
    resm1 = res - 1'b1;
    if ({1'b0, v} >= res) begin
      return resm1[PT_W-1:0];
    end
    return v;
  endfunction

endpackage

// ===== rtl/tpsd_cfg.sv =====
// ----------------------------------------------------------------------------
// tpsd_cfg
// APB-style register file holding the conditioner configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpsd_pkg::DATA_W-1:0]   pwdata,
  output logic [tpsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output tpsd_pkg::cfg_t                cfg
);
  import tpsd_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_HOR_RES:      cfg_nxt.hor_res      = pwdata[RES_W-1:0];
        REG_VER_RES:      cfg_nxt.ver_res      = pwdata[RES_W-1:0];
        REG_X_SCALE:      cfg_nxt.x_scale      = pwdata[SCALE_W-1:0];
        REG_Y_SCALE:      cfg_nxt.y_scale      = pwdata[SCALE_W-1:0];
        REG_BOTTOM_EDGE:  cfg_nxt.bottom_edge  = pwdata[EDGE_W-1:0];
        REG_EDGE_MARGIN:  cfg_nxt.edge_margin  = pwdata[EDGE_W-1:0];
        REG_MIN_RISE:     cfg_nxt.min_rise     = pwdata[EDGE_W-1:0];
        REG_MAX_SIDEWAYS: cfg_nxt.max_sideways = pwdata[EDGE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HOR_RES:      prdata = DATA_W'(cfg_r.hor_res);
      REG_VER_RES:      prdata = DATA_W'(cfg_r.ver_res);
      REG_X_SCALE:      prdata = DATA_W'(cfg_r.x_scale);
      REG_Y_SCALE:      prdata = DATA_W'(cfg_r.y_scale);
      REG_BOTTOM_EDGE:  prdata = DATA_W'(cfg_r.bottom_edge);
      REG_EDGE_MARGIN:  prdata = DATA_W'(cfg_r.edge_margin);
      REG_MIN_RISE:     prdata = DATA_W'(cfg_r.min_rise);
      REG_MAX_SIDEWAYS: prdata = DATA_W'(cfg_r.max_sideways);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hor_res      <= RST_HOR_RES;
      cfg_r.ver_res      <= RST_VER_RES;
      cfg_r.x_scale      <= RST_X_SCALE;
      cfg_r.y_scale      <= RST_Y_SCALE;
      cfg_r.bottom_edge  <= RST_BOTTOM_EDGE;
      cfg_r.edge_margin  <= RST_EDGE_MARGIN;
      cfg_r.min_rise     <= RST_MIN_RISE;
      cfg_r.max_sideways <= RST_MAX_SIDEWAYS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/tpsd_fifo.sv =====
// ----------------------------------------------------------------------------
// tpsd_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsd_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              full,
  output logic              empty
);
  import tpsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(wr_en) - CNT_W'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/tpsd_front.sv =====
// ----------------------------------------------------------------------------
// tpsd_front
// Press tracking and swipe-home classification of each accepted poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsd_front #(
  parameter int COORD_BITS = tpsd_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tpsd_pkg::cfg_t        cfg,
  input  logic                  accept,
  input  logic                  contact,
  input  logic                  suspended,
  input  logic [COORD_BITS-1:0] raw_x,
  input  logic [COORD_BITS-1:0] raw_y,
  output tpsd_pkg::flags_t      q_flags
);
  import tpsd_pkg::*;

  localparam int SW = ((COORD_BITS > EDGE_W) ? COORD_BITS : EDGE_W) + 2;

  logic                  press_active_r, press_active_nxt;
  logic [COORD_BITS-1:0] start_x_r, start_y_r, latest_x_r, latest_y_r;
  logic                  press;

  logic signed [SW-1:0]  sx, sy, lx, ly;
  logic signed [SW-1:0]  floor_y, rise, side, side_abs;
  logic signed [SW-1:0]  min_rise_s, max_side_s;
  logic                  swipe_ok;

  assign press = contact && !suspended;

  always_comb begin
    sx         = $signed({{(SW-COORD_BITS){1'b0}}, start_x_r});
    sy         = $signed({{(SW-COORD_BITS){1'b0}}, start_y_r});
    lx         = $signed({{(SW-COORD_BITS){1'b0}}, latest_x_r});
    ly         = $signed({{(SW-COORD_BITS){1'b0}}, latest_y_r});
    floor_y    = $signed({{(SW-EDGE_W){1'b0}}, cfg.bottom_edge})
               - $signed({{(SW-EDGE_W){1'b0}}, cfg.edge_margin});
    min_rise_s = $signed({{(SW-EDGE_W){1'b0}}, cfg.min_rise});
    max_side_s = $signed({{(SW-EDGE_W){1'b0}}, cfg.max_sideways});
    rise       = sy - ly;
    side       = sx - lx;
    side_abs   = side[SW-1] ? -side : side;
    swipe_ok   = (sy >= floor_y) && (rise >= min_rise_s) && (side_abs < max_side_s);
  end

  always_comb begin
    q_flags.pressed  = press;
    // Only a release that ends a press can flag a swipe.
    q_flags.swipe    = !press && press_active_r && swipe_ok;
    press_active_nxt = press_active_r;
    if (accept) begin
      press_active_nxt = press;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && press) begin
      if (!press_active_r) begin
        start_x_r <= raw_x;
        start_y_r <= raw_y;
      end
      latest_x_r <= raw_x;
      latest_y_r <= raw_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_active_r <= 1'b0;
    end else begin
      press_active_r <= press_active_nxt;
    end
  end

endmodule

// ===== rtl/tpsd_back.sv =====
// ----------------------------------------------------------------------------
// tpsd_back
// Scaling pipeline: multiply stage, then offset, clamp and result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpsd_back #(
  parameter int COORD_BITS = tpsd_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tpsd_pkg::cfg_t        cfg,
  input  logic                  q_empty,
  input  tpsd_pkg::flags_t      q_flags,
  input  logic [COORD_BITS-1:0] q_raw_x,
  input  logic [COORD_BITS-1:0] q_raw_y,
  output logic                  q_rd,
  input  logic                  o_full,
  output logic                  o_wr,
  output tpsd_pkg::res_t        o_res
);
  import tpsd_pkg::*;

  localparam int DW  = ((COORD_BITS > PT_W) ? COORD_BITS : PT_W) + 2;
  localparam int SCW = SCALE_W + 1;
  localparam int PW  = DW + SCW;
  localparam int VW  = PW + 1;
  localparam int QW  = VW - FRAC_W;

  logic                 m_v_r, m_v_nxt;
  flags_t               m_flags_r;
  logic signed [PW-1:0] m_prod_x_r, m_prod_y_r;
  logic signed [PW-1:0] prod_x_nxt, prod_y_nxt;
  logic [PT_W-1:0]      rep_x_r, rep_y_r;

  logic [RES_W-1:0]     res_x, res_y;
  logic signed [DW-1:0] d_x, d_y;
  logic [PT_W-1:0]      sc_x, sc_y;

  // (point - center) * scale + center * 4096, floored at zero, shifted down
  // and clamped to the last pixel.
  function automatic logic [PT_W-1:0] finish(input logic signed [PW-1:0] prod,
                                             input logic [RES_W-1:0]     res);
    logic [PT_W-1:0]      c;
    logic signed [VW-1:0] v;
    logic [QW-1:0]        q;
    logic [RES_W-1:0]     resm1;
    c     = res[RES_W-1:1];
    v     = VW'(prod) + $signed({{(VW-PT_W-FRAC_W){1'b0}}, c, {FRAC_W{1'b0}}});
    q     = v[VW-1:FRAC_W];
    resm1 = res - 1'b1;
    if (v[VW-1]) begin
      return '0;
    end else if (q >= QW'(res)) begin
      return resm1[PT_W-1:0];
    end
    return q[PT_W-1:0];
  endfunction

  assign res_x = eff_res(cfg.hor_res);
  assign res_y = eff_res(cfg.ver_res);

  assign o_wr = m_v_r && !o_full;
  assign q_rd = !q_empty && (!m_v_r || o_wr);

  always_comb begin
    d_x = $signed({{(DW-COORD_BITS){1'b0}}, q_raw_x})
        - $signed({{(DW-PT_W){1'b0}}, res_x[RES_W-1:1]});
    d_y = $signed({{(DW-COORD_BITS){1'b0}}, q_raw_y})
        - $signed({{(DW-PT_W){1'b0}}, res_y[RES_W-1:1]});
    prod_x_nxt = PW'(d_x) * PW'($signed({1'b0, cfg.x_scale}));
    prod_y_nxt = PW'(d_y) * PW'($signed({1'b0, cfg.y_scale}));
    m_v_nxt    = q_rd || (m_v_r && !o_wr);
  end

  always_comb begin
    sc_x = finish(m_prod_x_r, res_x);
    sc_y = finish(m_prod_y_r, res_y);
    o_res.pressed    = m_flags_r.pressed;
    o_res.swipe_home = m_flags_r.swipe;
    if (m_flags_r.pressed) begin
      o_res.point_x = sc_x;
      o_res.point_y = sc_y;
    end else begin
      o_res.point_x = clamp_pt(rep_x_r, res_x);
      o_res.point_y = clamp_pt(rep_y_r, res_y);
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      m_flags_r  <= q_flags;
      m_prod_x_r <= prod_x_nxt;
      m_prod_y_r <= prod_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      rep_x_r <= '0;
      rep_y_r <= '0;
    end else begin
      m_v_r <= m_v_nxt;
      if (o_wr && m_flags_r.pressed) begin
        rep_x_r <= sc_x;
        rep_y_r <= sc_y;
      end
    end
  end

endmodule

// ===== rtl/touch_point_conditioner_swipe_detect_top.sv =====
// ----------------------------------------------------------------------------
// touch_point_conditioner_swipe_detect_top
// Takes one poll per cycle while the hand-off queue has room; a result is
// registered in the hand-off queue, the multiply stage and the result queue.
// Sustained throughput is one poll per cycle, set by the multiply stage;
// push stalls only when the result queue backs up.
// Synchronous active-low reset empties both queues, ends any press and
// restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module touch_point_conditioner_swipe_detect_top #(
  parameter int COORD_BITS = tpsd_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_contact,
  input  logic                        in_suspended,
  input  logic [COORD_BITS-1:0]       in_raw_x,
  input  logic [COORD_BITS-1:0]       in_raw_y,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_pressed,
  output logic [tpsd_pkg::PT_W-1:0]   out_point_x,
  output logic [tpsd_pkg::PT_W-1:0]   out_point_y,
  output logic                        out_swipe_home,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpsd_pkg::ADDR_W-1:0] paddr,
  input  logic [tpsd_pkg::DATA_W-1:0] pwdata,
  output logic [tpsd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tpsd_pkg::*;

  localparam int QD_W = $bits(flags_t) + 2 * COORD_BITS;

  cfg_t                  cfg;
  logic                  in_acc;
  flags_t                f_flags, q_flags;
  logic [QD_W-1:0]       q_wdata, q_rdata;
  logic                  q_full, q_empty, q_rd;
  logic [COORD_BITS-1:0] q_raw_x, q_raw_y;
  logic                  o_wr, o_full, o_rd;
  res_t                  o_wres, o_rres;

  assign full   = q_full;
  assign in_acc = push && !q_full;
  assign o_rd   = pop && !empty;

  tpsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpsd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (in_acc),
    .contact   (in_contact),
    .suspended (in_suspended),
    .raw_x     (in_raw_x),
    .raw_y     (in_raw_y),
    .q_flags   (f_flags)
  );

  assign q_wdata = {f_flags, in_raw_x, in_raw_y};
  assign {q_flags, q_raw_x, q_raw_y} = q_rdata;

  tpsd_fifo #(
    .DATA_W (QD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  tpsd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_flags (q_flags),
    .q_raw_x (q_raw_x),
    .q_raw_y (q_raw_y),
    .q_rd    (q_rd),
    .o_full  (o_full),
    .o_wr    (o_wr),
    .o_res   (o_wres)
  );

  tpsd_fifo #(
    .DATA_W ($bits(res_t)),
    .DEPTH  (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (o_wr),
    .wr_data (o_wres),
    .rd_en   (o_rd),
    .rd_data (o_rres),
    .full    (o_full),
    .empty   (empty)
  );

  assign out_pressed    = o_rres.pressed;
  assign out_point_x    = o_rres.point_x;
  assign out_point_y    = o_rres.point_y;
  assign out_swipe_home = o_rres.swipe_home;

  // An accepted poll must be waiting in the hand-off queue on the next cycle.
  `ASSERT_NEXT(a_accept_lands, clk, rst_n, in_acc, !q_empty, "accepted poll lost")
  // A finished result must be visible to the consumer on the next cycle.
  `ASSERT_NEXT(a_result_lands, clk, rst_n, o_wr, !empty, "finished result lost")
  // A swipe can only be reported on a release.
  `ASSERT_IMP(a_press_no_swipe, clk, rst_n, !empty && out_pressed, !out_swipe_home,
              "swipe flagged on a press")

endmodule
